/* rtl/core/ssk_pkg.sv */
package ssk_pkg;

    // Store geometry and seed words
    localparam int          SSK_STORE_WORDS = 16;
    localparam logic [31:0] GOLD_WORD       = 32'h9e3779b9;
    localparam logic [31:0] FLEA_WORD       = 32'hf1ea5eed;

    // Request codes carried by the action field
    typedef enum logic [1:0] {
        ACT_RESET  = 2'd0,
        ACT_LOAD   = 2'd1,
        ACT_FINISH = 2'd2,
        ACT_DRAW   = 2'd3
    } action_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_MIX,
        ST_REFILL,
        ST_SKIP,
        ST_DRAW
    } state_t;

    // The four mixing accumulators
    typedef struct packed {
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
        logic [31:0] e;
    } acc_t;

endpackage

/* rtl/core/ssk_in_if.sv */
interface ssk_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [3:0]  key_index;
    logic [31:0] key_word;
    logic [2:0]  key_bytes;
    logic [15:0] skip_count;

    modport source (
        output valid, action, key_index, key_word, key_bytes, skip_count,
        input  ready
    );

    modport sink (
        input  valid, action, key_index, key_word, key_bytes, skip_count,
        output ready
    );
endinterface

/* rtl/core/ssk_out_if.sv */
interface ssk_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] random_value;

    modport source (
        output valid, random_value,
        input  ready
    );

    modport sink (
        input  valid, random_value,
        output ready
    );
endinterface

/* rtl/core/ssk_round.sv */
module ssk_round
    import ssk_pkg::*;
(
    input  acc_t        acc_in,
    input  logic [1:0]  rot_sel,
    input  logic [31:0] word,
    output acc_t        acc_out
);

    // Rotation triples, one row per selector value
    localparam int ROT_SHR [4] = '{29, 26, 15, 20};
    localparam int ROT_SHL [4] = '{12, 16, 18, 20};
    localparam int ROT_ROL [4] = '{16, 20, 12, 16};

    logic [31:0] shift_cand [4];
    logic [31:0] rol_cand   [4];
    logic [31:0] b_new;
    logic [31:0] c_new;
    logic [31:0] d_new;

    // Build the shift term for every row, then pick one
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            shift_cand[i] = (acc_in.e >> ROT_SHR[i]) | (acc_in.d << ROT_SHL[i]);
        end
    end

    assign b_new = acc_in.c ^ shift_cand[rot_sel];

    // Rotate the new b by every row amount
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            rol_cand[i] = (b_new << ROT_ROL[i]) | (b_new >> (32 - ROT_ROL[i]));
        end
    end

    assign c_new = acc_in.d - rol_cand[rot_sel];
    assign d_new = word + b_new;

    assign acc_out.b = b_new;
    assign acc_out.c = c_new;
    assign acc_out.d = d_new;
    assign acc_out.e = c_new + d_new;

endmodule

/* rtl/core/small_state_keystream_generator.sv */
// Draw: the output bank word is read through its registered read port, then loaded into the
// output register as the pointer advances; no new request is taken until the draw is back in idle.
// The last draw of a bank adds a refill (one round per cycle on the store memory). Reset is done in
// the idle state; a key load reads the stored word, then merges the key bytes and writes it back.
// Finish runs the mix pass, a refill and the skip step, plus a further refill and skip step for
// every bank boundary that the skipped draws cross. rst_n (async, active low) and the reset action
// restore seed words through per-entry valid bits at once: no clearing pass. Unwritten output bank words read as zero.
module small_state_keystream_generator
    import ssk_pkg::*;
#(
    parameter int STORE_WORDS = SSK_STORE_WORDS
)
(
    input  logic      clk,
    input  logic      rst_n,
    ssk_in_if.sink    in_ch,
    ssk_out_if.source out_ch
);

    localparam int              IDX_W    = $clog2(STORE_WORDS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(STORE_WORDS - 1);
    localparam logic [IDX_W:0]   BANK_LEN = (IDX_W + 1)'(STORE_WORDS);

    // Control state
    state_t                 state_reg,       state_next;
    acc_t                   acc_reg,         acc_next;
    logic [IDX_W-1:0]       ptr_reg,         ptr_next;
    logic [1:0]             rot_reg,         rot_next;
    logic [IDX_W-1:0]       cnt_reg,         cnt_next;
    logic [15:0]            skip_reg,        skip_next;
    logic                   skip_mode_reg,   skip_mode_next;
    logic                   res_valid_reg,   res_valid_next;
    logic [STORE_WORDS-1:0] mbank_valid_reg, mbank_valid_next;
    logic [STORE_WORDS-1:0] obank_valid_reg, obank_valid_next;
    logic                   pw_en_reg;

    // Payload registers
    logic [31:0]      res_data_reg, res_data_next;
    logic [IDX_W-1:0] key_idx_reg,  key_idx_next;
    logic [31:0]      key_word_reg, key_word_next;
    logic [31:0]      key_mask_reg, key_mask_next;
    logic [IDX_W-1:0] pw_idx_reg;
    logic [31:0]      pw_data_reg;

    // Store memories
    logic [31:0]      mix_mem [STORE_WORDS];
    logic [31:0]      out_mem [STORE_WORDS];
    logic [31:0]      mix_rdata_reg;
    logic             mix_rvalid_reg;
    logic [IDX_W-1:0] mix_ridx_reg;
    logic [31:0]      out_rdata_reg;
    logic             out_rvalid_reg;

    logic             mix_we;
    logic [IDX_W-1:0] mix_waddr;
    logic [31:0]      mix_wdata;
    logic [IDX_W-1:0] mix_raddr;
    logic             out_we;
    logic [IDX_W-1:0] out_waddr;
    logic [31:0]      out_wdata;
    logic [IDX_W-1:0] out_raddr;

    logic             in_ready;
    logic [31:0]      word_mem;
    logic [31:0]      round_word;
    acc_t             acc_step;
    logic [IDX_W:0]   dist_to_wrap;

    // Byte mask for a key load; counts above four act as four
    function automatic logic [31:0] key_mask(input logic [2:0] nbytes);
        logic [31:0] m;
        case (nbytes) inside
            3'd0:         m = 32'h0000_0000;
            3'd1:         m = 32'h0000_00ff;
            3'd2:         m = 32'h0000_ffff;
            3'd3:         m = 32'h00ff_ffff;
            [3'd4:3'd7]:  m = 32'hffff_ffff;
            default:      m = 32'hffff_ffff;
        endcase
        return m;
    endfunction

    // Mix store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mix_we)
        begin
            mix_mem[mix_waddr] <= mix_wdata;
        end
        mix_rdata_reg  <= mix_mem[mix_raddr];
        mix_rvalid_reg <= mbank_valid_reg[mix_raddr];
        mix_ridx_reg   <= mix_raddr;
        pw_idx_reg     <= mix_waddr;
        pw_data_reg    <= mix_wdata;
    end

    // Output bank: written by refill, read by draw
    always_ff @(posedge clk)
    begin
        if (out_we)
        begin
            out_mem[out_waddr] <= out_wdata;
        end
        out_rdata_reg  <= out_mem[out_raddr];
        out_rvalid_reg <= obank_valid_reg[out_raddr];
    end

    // Forward the write made in the read cycle; unwritten words read as the seed
    assign word_mem = (pw_en_reg && (pw_idx_reg == mix_ridx_reg)) ? pw_data_reg :
                      (mix_rvalid_reg ? mix_rdata_reg : GOLD_WORD);

    // A refill writes its target before reading, so forward that write too
    assign round_word = ((state_reg == ST_REFILL) && (acc_reg.c[IDX_W-1:0] == cnt_reg)) ?
                        acc_reg.e : word_mem;

    ssk_round u_round (
        .acc_in  (acc_reg),
        .rot_sel (rot_reg),
        .word    (round_word),
        .acc_out (acc_step)
    );

    assign dist_to_wrap = BANK_LEN - {1'b0, ptr_reg};

    // Next state and datapath control
    always_comb
    begin
        state_next       = state_reg;
        acc_next         = acc_reg;
        ptr_next         = ptr_reg;
        rot_next         = rot_reg;
        cnt_next         = cnt_reg;
        skip_next        = skip_reg;
        skip_mode_next   = skip_mode_reg;
        res_valid_next   = res_valid_reg;
        res_data_next    = res_data_reg;
        key_idx_next     = key_idx_reg;
        key_word_next    = key_word_reg;
        key_mask_next    = key_mask_reg;
        mbank_valid_next = mbank_valid_reg;
        obank_valid_next = obank_valid_reg;
        in_ready         = 1'b0;
        mix_we           = 1'b0;
        mix_waddr        = cnt_reg;
        mix_wdata        = acc_step.e;
        mix_raddr        = cnt_reg + IDX_W'(1);
        out_we           = 1'b0;
        out_waddr        = cnt_reg;
        out_wdata        = acc_step.c;
        out_raddr        = ptr_reg;

        // Drop the result once the sink takes it
        if (res_valid_reg && out_ch.ready)
        begin
            res_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = !res_valid_reg || out_ch.ready;
                if (in_ch.valid && in_ready)
                begin
                    case (action_t'(in_ch.action))
                        ACT_RESET:
                        begin
                            acc_next         = '{FLEA_WORD, FLEA_WORD, FLEA_WORD, FLEA_WORD};
                            ptr_next         = '0;
                            rot_next         = '0;
                            mbank_valid_next = '0;
                            obank_valid_next = '0;
                        end
                        ACT_LOAD:
                        begin
                            mix_raddr     = in_ch.key_index[IDX_W-1:0];
                            key_idx_next  = in_ch.key_index[IDX_W-1:0];
                            key_word_next = in_ch.key_word;
                            key_mask_next = key_mask(in_ch.key_bytes);
                            state_next    = ST_LOAD;
                        end
                        ACT_FINISH:
                        begin
                            mix_raddr  = '0;
                            cnt_next   = '0;
                            skip_next  = in_ch.skip_count;
                            state_next = ST_MIX;
                        end
                        ACT_DRAW:
                        begin
                            out_raddr  = ptr_reg;
                            state_next = ST_DRAW;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_LOAD:
            begin
                // Merge key bytes into the stored word
                mix_we     = 1'b1;
                mix_waddr  = key_idx_reg;
                mix_wdata  = (word_mem & ~key_mask_reg) | (key_word_reg & key_mask_reg);
                state_next = ST_IDLE;
            end

            ST_MIX:
            begin
                // One round per word, written back in place
                acc_next  = acc_step;
                mix_we    = 1'b1;
                mix_waddr = cnt_reg;
                mix_wdata = acc_step.e;
                cnt_next  = cnt_reg + IDX_W'(1);
                if (cnt_reg == LAST_IDX)
                begin
                    skip_mode_next = 1'b1;
                    state_next     = ST_REFILL;
                end
            end

            ST_REFILL:
            begin
                // Scatter e, run a round, emit c into the output bank
                acc_next  = acc_step;
                mix_we    = 1'b1;
                mix_waddr = acc_reg.c[IDX_W-1:0];
                mix_wdata = acc_reg.e;
                out_we    = 1'b1;
                out_waddr = cnt_reg;
                out_wdata = acc_step.c;
                cnt_next  = cnt_reg + IDX_W'(1);
                if (cnt_reg == LAST_IDX)
                begin
                    rot_next   = acc_step.d[1:0];
                    state_next = skip_mode_reg ? ST_SKIP : ST_IDLE;
                end
            end

            ST_SKIP:
            begin
                // Jump the pointer over whole stretches of discarded draws
                if (skip_reg >= 16'(dist_to_wrap))
                begin
                    skip_next  = skip_reg - 16'(dist_to_wrap);
                    ptr_next   = '0;
                    mix_raddr  = '0;
                    cnt_next   = '0;
                    state_next = ST_REFILL;
                end
                else
                begin
                    ptr_next   = ptr_reg + skip_reg[IDX_W-1:0];
                    skip_next  = '0;
                    state_next = ST_IDLE;
                end
            end

            ST_DRAW:
            begin
                // Load the result register and advance the pointer
                res_data_next  = out_rvalid_reg ? out_rdata_reg : '0;
                res_valid_next = 1'b1;
                ptr_next       = ptr_reg + IDX_W'(1);
                if (ptr_reg == LAST_IDX)
                begin
                    mix_raddr      = '0;
                    cnt_next       = '0;
                    skip_mode_next = 1'b0;
                    state_next     = ST_REFILL;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Mark written words valid
        if (mix_we)
        begin
            mbank_valid_next[mix_waddr] = 1'b1;
        end
        if (out_we)
        begin
            obank_valid_next[out_waddr] = 1'b1;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            acc_reg         <= '{FLEA_WORD, FLEA_WORD, FLEA_WORD, FLEA_WORD};
            ptr_reg         <= '0;
            rot_reg         <= '0;
            cnt_reg         <= '0;
            skip_reg        <= '0;
            skip_mode_reg   <= 1'b0;
            res_valid_reg   <= 1'b0;
            mbank_valid_reg <= '0;
            obank_valid_reg <= '0;
            pw_en_reg       <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            acc_reg         <= acc_next;
            ptr_reg         <= ptr_next;
            rot_reg         <= rot_next;
            cnt_reg         <= cnt_next;
            skip_reg        <= skip_next;
            skip_mode_reg   <= skip_mode_next;
            res_valid_reg   <= res_valid_next;
            mbank_valid_reg <= mbank_valid_next;
            obank_valid_reg <= obank_valid_next;
            pw_en_reg       <= mix_we;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        res_data_reg <= res_data_next;
        key_idx_reg  <= key_idx_next;
        key_word_reg <= key_word_next;
        key_mask_reg <= key_mask_next;
    end

    assign in_ch.ready         = in_ready;
    assign out_ch.valid        = res_valid_reg;
    assign out_ch.random_value = res_data_reg;

endmodule
